[sv/dnsa_pkg.sv]
`default_nettype none
package dnsa_pkg;

	localparam int MAX_MESSAGE_BYTES = 512;
	localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);

	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_MESSAGE_BYTES);
	localparam logic [POS_W-1:0] HEADER_BYTES = POS_W'(12);
	localparam logic [POS_W-1:0] POS_COUNT_HI = POS_W'(6);
	localparam logic [POS_W-1:0] POS_COUNT_LO = POS_W'(7);
	localparam logic [POS_W-1:0] POS_HEADER_END = POS_W'(11);

	localparam logic [7:0] PTR_MASK = 8'hC0;
	localparam logic [3:0] FIXED_BYTES = 4'd10;
	localparam logic [3:0] TYPE_BYTES = 4'd2;
	localparam logic [3:0] LENGTH_START = 4'd8;
	localparam logic [3:0] ADDR_BYTES = 4'd4;
	localparam logic [15:0] QTAIL_BYTES = 16'd4;
	localparam logic [15:0] QPTR_TAIL_BYTES = 16'd5;
	localparam logic [15:0] TYPE_A = 16'd1;
	localparam logic [15:0] ADDR_LENGTH = 16'd4;

	localparam logic [3:0] PH_HEADER = 4'd0;
	localparam logic [3:0] PH_QNAME = 4'd1;
	localparam logic [3:0] PH_QLABEL = 4'd2;
	localparam logic [3:0] PH_QTAIL = 4'd3;
	localparam logic [3:0] PH_ANAME = 4'd4;
	localparam logic [3:0] PH_ALABEL = 4'd5;
	localparam logic [3:0] PH_APTR = 4'd6;
	localparam logic [3:0] PH_AFIX = 4'd7;
	localparam logic [3:0] PH_ASKIP = 4'd8;
	localparam logic [3:0] PH_ADATA = 4'd9;
	localparam logic [3:0] PH_FOUND = 4'd10;
	localparam logic [3:0] PH_NOMORE = 4'd11;
	localparam logic [3:0] PH_NOANS = 4'd12;

	typedef enum logic [1:0] {
		ST_FOUND = 2'd0,
		ST_SHORT = 2'd1,
		ST_NO_ANSWERS = 2'd2,
		ST_NO_A_RECORD = 2'd3
	} status_t;

endpackage
`default_nettype wire

[sv/dns_answer_a_record_extractor_core.sv]
// Channel  Handshake                  Payload
// input    byte_valid / byte_stall    data_byte, last_byte
// output   result_valid / result_stall status, ipv4_address
//
// One word is taken per cycle unless byte_stall is high; the parse state is updated in
// the cycle the word is taken. A message's result is registered when its last word is
// taken. A result register and one skid register sit on the output,
// so input stalls only when both hold a result.
// Reset clears the parse state and empties both result registers.
`default_nettype none
module dns_answer_a_record_extractor_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic byte_valid,
	output logic byte_stall,
	input wire logic [7:0] data_byte,
	input wire logic last_byte,
	output logic result_valid,
	input wire logic result_stall,
	output logic [1:0] status,
	output logic [31:0] ipv4_address
);

	logic [dnsa_pkg::POS_W-1:0] pos_q, pos_d;
	logic [3:0] phase_q, phase_d;
	logic [15:0] ans_q, ans_d;
	logic [15:0] skip_q, skip_d;
	logic [15:0] rtype_q, rtype_d;
	logic [15:0] rlen_q, rlen_d;
	logic [3:0] idx_q, idx_d;
	logic [31:0] addr_q, addr_d;
	logic done_q, done_d;

	logic take_in, push, take_out;
	dnsa_pkg::status_t new_status;
	logic [31:0] new_addr;

	logic result_valid_q, skid_valid_q;
	dnsa_pkg::status_t status_q, skid_status_q;
	logic [31:0] addr_out_q, skid_addr_q;

	assign byte_stall = skid_valid_q;
	assign take_in = byte_valid & ~byte_stall;
	assign push = take_in & last_byte;
	assign take_out = result_valid_q & ~result_stall;

	always_comb begin
		pos_d = pos_q;
		phase_d = phase_q;
		ans_d = ans_q;
		skip_d = skip_q;
		rtype_d = rtype_q;
		rlen_d = rlen_q;
		idx_d = idx_q;
		addr_d = addr_q;
		done_d = done_q;
		if (pos_q < dnsa_pkg::MAX_POS) begin
			pos_d = pos_q + 1'b1;
			if (!done_q) begin
				case (phase_q)
					dnsa_pkg::PH_HEADER: begin
						if (pos_q == dnsa_pkg::POS_COUNT_HI)
							ans_d = {data_byte, 8'h00};
						if (pos_q == dnsa_pkg::POS_COUNT_LO)
							ans_d = {ans_q[15:8], data_byte};
						if (pos_q == dnsa_pkg::POS_HEADER_END) begin
							if (ans_q == 16'd0) begin
								phase_d = dnsa_pkg::PH_NOANS;
								done_d = 1'b1;
							end else begin
								phase_d = dnsa_pkg::PH_QNAME;
							end
						end
					end
					dnsa_pkg::PH_QNAME: begin
						if (data_byte == 8'd0) begin
							skip_d = dnsa_pkg::QTAIL_BYTES;
							phase_d = dnsa_pkg::PH_QTAIL;
						end else if ((data_byte & dnsa_pkg::PTR_MASK) == dnsa_pkg::PTR_MASK) begin
							skip_d = dnsa_pkg::QPTR_TAIL_BYTES;
							phase_d = dnsa_pkg::PH_QTAIL;
						end else begin
							skip_d = {8'd0, data_byte};
							phase_d = dnsa_pkg::PH_QLABEL;
						end
					end
					dnsa_pkg::PH_QLABEL, dnsa_pkg::PH_QTAIL, dnsa_pkg::PH_ALABEL,
					dnsa_pkg::PH_ASKIP: begin
						if (skip_q <= 16'd1) begin
							skip_d = 16'd0;
							if (phase_q == dnsa_pkg::PH_QLABEL) begin
								phase_d = dnsa_pkg::PH_QNAME;
							end else if (phase_q == dnsa_pkg::PH_ASKIP) begin
								ans_d = ans_q - 1'b1;
								if (ans_d == 16'd0) begin
									phase_d = dnsa_pkg::PH_NOMORE;
									done_d = 1'b1;
								end else begin
									phase_d = dnsa_pkg::PH_ANAME;
								end
							end else begin
								phase_d = dnsa_pkg::PH_ANAME;
							end
						end else begin
							skip_d = skip_q - 1'b1;
						end
					end
					dnsa_pkg::PH_ANAME: begin
						if (data_byte == 8'd0) begin
							idx_d = 4'd0;
							phase_d = dnsa_pkg::PH_AFIX;
						end else if ((data_byte & dnsa_pkg::PTR_MASK) == dnsa_pkg::PTR_MASK) begin
							phase_d = dnsa_pkg::PH_APTR;
						end else begin
							skip_d = {8'd0, data_byte};
							phase_d = dnsa_pkg::PH_ALABEL;
						end
					end
					dnsa_pkg::PH_APTR: begin
						idx_d = 4'd0;
						phase_d = dnsa_pkg::PH_AFIX;
					end
					dnsa_pkg::PH_AFIX: begin
						if (idx_q < dnsa_pkg::TYPE_BYTES)
							rtype_d = {rtype_q[7:0], data_byte};
						if (idx_q >= dnsa_pkg::LENGTH_START)
							rlen_d = {rlen_q[7:0], data_byte};
						idx_d = idx_q + 1'b1;
						if (idx_d >= dnsa_pkg::FIXED_BYTES) begin
							idx_d = 4'd0;
							if (rtype_d == dnsa_pkg::TYPE_A && rlen_d == dnsa_pkg::ADDR_LENGTH) begin
								addr_d = 32'd0;
								phase_d = dnsa_pkg::PH_ADATA;
							end else if (rlen_d == 16'd0) begin
								ans_d = ans_q - 1'b1;
								if (ans_d == 16'd0) begin
									phase_d = dnsa_pkg::PH_NOMORE;
									done_d = 1'b1;
								end else begin
									phase_d = dnsa_pkg::PH_ANAME;
								end
							end else begin
								skip_d = rlen_d;
								phase_d = dnsa_pkg::PH_ASKIP;
							end
						end
					end
					dnsa_pkg::PH_ADATA: begin
						addr_d = {addr_q[23:0], data_byte};
						idx_d = idx_q + 1'b1;
						if (idx_d >= dnsa_pkg::ADDR_BYTES) begin
							phase_d = dnsa_pkg::PH_FOUND;
							done_d = 1'b1;
						end
					end
					default: begin
						done_d = 1'b1;
					end
				endcase
			end
		end
	end

	always_comb begin
		new_addr = 32'd0;
		if (pos_d < dnsa_pkg::HEADER_BYTES) begin
			new_status = dnsa_pkg::ST_SHORT;
		end else if (phase_d == dnsa_pkg::PH_NOANS) begin
			new_status = dnsa_pkg::ST_NO_ANSWERS;
		end else if (phase_d == dnsa_pkg::PH_FOUND) begin
			new_status = dnsa_pkg::ST_FOUND;
			new_addr = addr_d;
		end else begin
			new_status = dnsa_pkg::ST_NO_A_RECORD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			phase_q <= dnsa_pkg::PH_HEADER;
			ans_q <= 16'd0;
			skip_q <= 16'd0;
			rtype_q <= 16'd0;
			rlen_q <= 16'd0;
			idx_q <= 4'd0;
			addr_q <= 32'd0;
			done_q <= 1'b0;
		end else if (take_in) begin
			if (last_byte) begin
				pos_q <= '0;
				phase_q <= dnsa_pkg::PH_HEADER;
				ans_q <= 16'd0;
				skip_q <= 16'd0;
				rtype_q <= 16'd0;
				rlen_q <= 16'd0;
				idx_q <= 4'd0;
				addr_q <= 32'd0;
				done_q <= 1'b0;
			end else begin
				pos_q <= pos_d;
				phase_q <= phase_d;
				ans_q <= ans_d;
				skip_q <= skip_d;
				rtype_q <= rtype_d;
				rlen_q <= rlen_d;
				idx_q <= idx_d;
				addr_q <= addr_d;
				done_q <= done_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take_out) begin
				result_valid_q <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
			if (push) begin
				if (!result_valid_q || (take_out && !skid_valid_q))
					result_valid_q <= 1'b1;
				else
					skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_out && skid_valid_q) begin
			status_q <= skid_status_q;
			addr_out_q <= skid_addr_q;
		end
		if (push) begin
			if (!result_valid_q || (take_out && !skid_valid_q)) begin
				status_q <= new_status;
				addr_out_q <= new_addr;
			end else begin
				skid_status_q <= new_status;
				skid_addr_q <= new_addr;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign status = status_q;
	assign ipv4_address = addr_out_q;

endmodule
`default_nettype wire
